@@ design/hasg_pkg.sv @@
// Shared types for the squared-area and gradient pipeline.
`timescale 1ns / 1ps

package hasg_pkg;

  localparam int unsigned LenW    = 15;
  localparam int unsigned FactorW = 18;
  localparam int unsigned ResW    = 63;

  typedef logic [LenW-1:0] len_t;

  // Sorted position that one original side took: A largest, C smallest.
  typedef enum logic [1:0] {
    POS_A = 2'd0,
    POS_B = 2'd1,
    POS_C = 2'd2
  } pos_t;

  typedef struct packed {
    len_t a;
    len_t b;
    len_t c;
    pos_t pos_i;
    pos_t pos_j;
    pos_t pos_k;
  } sort_t;

endpackage

@@ design/hasg_sort.sv @@
// Three-way sort of the side lengths with the sorted position of each side.
`timescale 1ns / 1ps

module hasg_sort (
  input  hasg_pkg::len_t  len_i,
  input  hasg_pkg::len_t  len_j,
  input  hasg_pkg::len_t  len_k,
  output hasg_pkg::sort_t sorted
);

  logic       ge_ij;
  logic       ge_ik;
  logic       ge_jk;
  logic [1:0] rank_i;
  logic [1:0] rank_j;
  logic [1:0] rank_k;

  // Ties go to the earlier side, so the ranks always form a permutation.
  assign ge_ij = (len_i >= len_j);
  assign ge_ik = (len_i >= len_k);
  assign ge_jk = (len_j >= len_k);

  assign rank_i = {1'b0, ~ge_ij} + {1'b0, ~ge_ik};
  assign rank_j = {1'b0, ge_ij} + {1'b0, ~ge_jk};
  assign rank_k = {1'b0, ge_ik} + {1'b0, ge_jk};

  always_comb begin
    sorted.pos_i = hasg_pkg::pos_t'(rank_i);
    sorted.pos_j = hasg_pkg::pos_t'(rank_j);
    sorted.pos_k = hasg_pkg::pos_t'(rank_k);

    if (rank_i == 2'd0) begin
      sorted.a = len_i;
    end else if (rank_j == 2'd0) begin
      sorted.a = len_j;
    end else begin
      sorted.a = len_k;
    end

    if (rank_i == 2'd1) begin
      sorted.b = len_i;
    end else if (rank_j == 2'd1) begin
      sorted.b = len_j;
    end else begin
      sorted.b = len_k;
    end

    if (rank_i == 2'd2) begin
      sorted.c = len_i;
    end else if (rank_j == 2'd2) begin
      sorted.c = len_j;
    end else begin
      sorted.c = len_k;
    end
  end

endmodule

@@ design/heron_area_sq_and_gradient.sv @@
// Top level: pipelined squared triangle area and side-length gradients.
// Each accepted triangle moves through six register stages, the first one loaded at the
// input transaction edge; out_tvalid is the valid bit of the last stage.
// Throughput: one triangle per cycle; the whole six-stage pipe advances together
// whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous): clears every stage valid bit and log_mode.
`timescale 1ns / 1ps

module heron_area_sq_and_gradient (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration write channel: bit 0 = log_mode
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,
  // Input stream, tdata from bit 0: len_i[14:0], len_j[29:15], len_k[44:30], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,
  // Output stream, tdata from bit 0: area_sq[62:0], grad_i[125:63],
  // grad_j[188:126], grad_k[251:189], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [255:0] out_tdata
);

  localparam int unsigned FW  = hasg_pkg::FactorW;  // one Heron factor
  localparam int unsigned PW  = 2 * FW;             // pair product
  localparam int unsigned TW  = 3 * FW;             // triple product
  localparam int unsigned SW  = 59;                 // gradient sum, exact range
  localparam int unsigned RW  = hasg_pkg::ResW;

  // ------------------------------------------------------------------
  // Pipe control: every stage moves when the output register can take
  // the item in front of it. Bubbles travel as cleared valid bits.
  // ------------------------------------------------------------------
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic log_mode_r;

  assign adv        = out_tready || !v6_r;
  assign in_tready  = adv;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      log_mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: sort the sides, remember where each one landed.
  // ------------------------------------------------------------------
  hasg_pkg::len_t  in_len_i;
  hasg_pkg::len_t  in_len_j;
  hasg_pkg::len_t  in_len_k;
  hasg_pkg::sort_t sort_nxt;
  hasg_pkg::sort_t s1_r;
  hasg_pkg::len_t  s1_li_r, s1_lj_r, s1_lk_r;

  assign in_len_i = in_tdata[14:0];
  assign in_len_j = in_tdata[29:15];
  assign in_len_k = in_tdata[44:30];

  hasg_sort u_sort (
    .len_i  (in_len_i),
    .len_j  (in_len_j),
    .len_k  (in_len_k),
    .sorted (sort_nxt)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r    <= sort_nxt;
      s1_li_r <= in_len_i;
      s1_lj_r <= in_len_j;
      s1_lk_r <= in_len_k;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: stable Heron factors S, P, Q, R.
  // ------------------------------------------------------------------
  logic signed [FW-1:0] ea, eb, ec;
  logic signed [FW-1:0] s_nxt, p_nxt, q_nxt, r_nxt;
  logic signed [FW-1:0] s2_s_r, s2_p_r, s2_q_r, s2_r_r;
  hasg_pkg::pos_t       s2_pi_r, s2_pj_r, s2_pk_r;
  hasg_pkg::len_t       s2_li_r, s2_lj_r, s2_lk_r;

  assign ea    = $signed({3'b000, s1_r.a});
  assign eb    = $signed({3'b000, s1_r.b});
  assign ec    = $signed({3'b000, s1_r.c});
  assign s_nxt = ea + (eb + ec);
  assign p_nxt = ec - (ea - eb);
  assign q_nxt = ec + (ea - eb);
  assign r_nxt = ea + (eb - ec);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s_r  <= s_nxt;
      s2_p_r  <= p_nxt;
      s2_q_r  <= q_nxt;
      s2_r_r  <= r_nxt;
      s2_pi_r <= s1_r.pos_i;
      s2_pj_r <= s1_r.pos_j;
      s2_pk_r <= s1_r.pos_k;
      s2_li_r <= s1_li_r;
      s2_lj_r <= s1_lj_r;
      s2_lk_r <= s1_lk_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: pair products PQ, SQ, SP; carry Q and R for the next step.
  // ------------------------------------------------------------------
  logic signed [PW-1:0] pq_nxt, sq_nxt, sp_nxt;
  logic signed [PW-1:0] s3_pq_r, s3_sq_r, s3_sp_r;
  logic signed [FW-1:0] s3_q_r, s3_r_r;
  hasg_pkg::pos_t       s3_pi_r, s3_pj_r, s3_pk_r;
  hasg_pkg::len_t       s3_li_r, s3_lj_r, s3_lk_r;

  assign pq_nxt = s2_p_r * s2_q_r;
  assign sq_nxt = s2_s_r * s2_q_r;
  assign sp_nxt = s2_s_r * s2_p_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pq_r <= pq_nxt;
      s3_sq_r <= sq_nxt;
      s3_sp_r <= sp_nxt;
      s3_q_r  <= s2_q_r;
      s3_r_r  <= s2_r_r;
      s3_pi_r <= s2_pi_r;
      s3_pj_r <= s2_pj_r;
      s3_pk_r <= s2_pk_r;
      s3_li_r <= s2_li_r;
      s3_lj_r <= s2_lj_r;
      s3_lk_r <= s2_lk_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: the four triple products, each missing one factor.
  // ------------------------------------------------------------------
  logic signed [TW-1:0] no_s_nxt, no_p_nxt, no_q_nxt, no_r_nxt;
  logic signed [TW-1:0] s4_no_s_r, s4_no_p_r, s4_no_q_r, s4_no_r_r;
  logic signed [FW-1:0] s4_q_r;
  hasg_pkg::pos_t       s4_pi_r, s4_pj_r, s4_pk_r;
  hasg_pkg::len_t       s4_li_r, s4_lj_r, s4_lk_r;

  assign no_s_nxt = s3_pq_r * s3_r_r;
  assign no_p_nxt = s3_sq_r * s3_r_r;
  assign no_q_nxt = s3_sp_r * s3_r_r;
  assign no_r_nxt = s3_sp_r * s3_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_no_s_r <= no_s_nxt;
      s4_no_p_r <= no_p_nxt;
      s4_no_q_r <= no_q_nxt;
      s4_no_r_r <= no_r_nxt;
      s4_q_r    <= s3_q_r;
      s4_pi_r   <= s3_pi_r;
      s4_pj_r   <= s3_pj_r;
      s4_pk_r   <= s3_pk_r;
      s4_li_r   <= s3_li_r;
      s4_lj_r   <= s3_lj_r;
      s4_lk_r   <= s3_lk_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: full product S*P*Q*R (kept modulo 2^64) and the signed
  // gradient sums; the term without the side's own factor is negated.
  // ------------------------------------------------------------------
  function automatic logic signed [SW-1:0] grad_sum(
    input hasg_pkg::pos_t       pos,
    input logic signed [TW-1:0] ns,
    input logic signed [TW-1:0] np,
    input logic signed [TW-1:0] nq,
    input logic signed [TW-1:0] nr
  );
    logic signed [SW-1:0] xs, xp, xq, xr;
    xs = SW'(ns);
    xp = SW'(np);
    xq = SW'(nq);
    xr = SW'(nr);
    case (pos)
      hasg_pkg::POS_A: grad_sum = xs - xp + xq + xr;
      hasg_pkg::POS_B: grad_sum = xs + xp - xq + xr;
      hasg_pkg::POS_C: grad_sum = xs + xp + xq - xr;
      default:         grad_sum = xs + xp + xq - xr;
    endcase
  endfunction

  logic signed [TW+FW-1:0] prod_full;
  logic [63:0]             s5_prod_r;
  logic signed [SW-1:0]    s5_gi_r, s5_gj_r, s5_gk_r;
  hasg_pkg::len_t          s5_li_r, s5_lj_r, s5_lk_r;

  assign prod_full = s4_no_q_r * s4_q_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_prod_r <= prod_full[63:0];
      s5_gi_r   <= grad_sum(s4_pi_r, s4_no_s_r, s4_no_p_r, s4_no_q_r, s4_no_r_r);
      s5_gj_r   <= grad_sum(s4_pj_r, s4_no_s_r, s4_no_p_r, s4_no_q_r, s4_no_r_r);
      s5_gk_r   <= grad_sum(s4_pk_r, s4_no_s_r, s4_no_p_r, s4_no_q_r, s4_no_r_r);
      s5_li_r   <= s4_li_r;
      s5_lj_r   <= s4_lj_r;
      s5_lk_r   <= s4_lk_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6 (output register): floor-shift the area; scale each gradient
  // by 16, or in log mode by own length then floor-shift by 5.
  // ------------------------------------------------------------------
  function automatic logic [RW-1:0] grad_out(
    input logic                 log_mode,
    input logic signed [SW-1:0] sum,
    input hasg_pkg::len_t       own
  );
    logic signed [SW+16-1:0] m;
    m = sum * $signed({1'b0, own});
    if (log_mode) begin
      grad_out = {{4{m[63]}}, m[63:5]};
    end else begin
      grad_out = {sum[SW-1:0], 4'b0000};
    end
  endfunction

  logic [RW-1:0] area_nxt;
  logic [RW-1:0] area_sq_r, grad_i_r, grad_j_r, grad_k_r;

  assign area_nxt = {{3{s5_prod_r[63]}}, s5_prod_r[63:4]};

  always_ff @(posedge clk) begin
    if (adv) begin
      area_sq_r <= area_nxt;
      grad_i_r  <= grad_out(log_mode_r, s5_gi_r, s5_li_r);
      grad_j_r  <= grad_out(log_mode_r, s5_gj_r, s5_lj_r);
      grad_k_r  <= grad_out(log_mode_r, s5_gk_r, s5_lk_r);
    end
  end

  assign out_tdata = {4'b0000, grad_k_r, grad_j_r, grad_i_r, area_sq_r};

`ifndef NO_ASSERTIONS
  // Sorted positions of the three sides must be a permutation.
  a_pos_perm: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (s1_r.pos_i != s1_r.pos_j) && (s1_r.pos_i != s1_r.pos_k) &&
             (s1_r.pos_j != s1_r.pos_k))
    else $error("sorted positions collide");

  // Sort must order the lengths largest first.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (s1_r.a >= s1_r.b) && (s1_r.b >= s1_r.c))
    else $error("sort order broken");

  // S, Q and R of a sorted triple are never negative.
  a_factor_sign: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> !s2_s_r[FW-1] && !s2_q_r[FW-1] && !s2_r_r[FW-1])
    else $error("Heron factor sign wrong");

  // A held output stalls the whole pipe: stage valids do not move.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && !out_tready) |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r}))
    else $error("pipe advanced during stall");
`endif

endmodule
